// ----- rtl/pca_pkg.sv -----
// Package for the pixel color adjust block: pixel types, register indexes
// and the fixed constants of the adjustment arithmetic.
// No dependencies.
package pca_pkg;

  typedef struct packed {
    logic [7:0] alpha_in;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] alpha_out;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pix_out_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONTRAST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RED_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_GAIN  = 3'd5;

  localparam logic [6:0] BRIGHTNESS_DEFAULT = 7'd100;
  localparam logic [7:0] CONTRAST_DEFAULT   = 8'd100;
  localparam logic [7:0] GAIN_DEFAULT       = 8'd100;
  localparam logic [6:0] BRI_MIN            = 7'd50;
  localparam logic [6:0] BRI_MAX            = 7'd100;
  localparam logic [7:0] PCT_MIN            = 8'd50;
  localparam logic [7:0] PCT_MAX            = 8'd150;

  localparam logic signed [16:0] MID_LEVEL  = 17'sd128;
  localparam logic signed [16:0] ROUND_HALF = 17'sd50;
  localparam logic [8:0]         MAX_LEVEL  = 9'd255;

  // Reciprocal of 100 scaled by 2**23; exact floor division for values below 91180.
  localparam logic [16:0] RECIP_100 = 17'd83887;
  localparam int unsigned RECIP_SH  = 23;

  // Magnitude divided by 100, truncated.
  function automatic logic [8:0] quo100(input logic [15:0] m);
    logic [32:0] prod;
    prod = {17'b0, m} * {16'b0, RECIP_100};
    return prod[RECIP_SH+8:RECIP_SH];
  endfunction

  // Absolute value of a signed numerator.
  function automatic logic [15:0] mag17(input logic signed [16:0] n);
    logic signed [16:0] a;
    a = n[16] ? -n : n;
    return a[15:0];
  endfunction

  // Restores the sign of a quotient.
  function automatic logic signed [16:0] signed_q(input logic [8:0] q, input logic neg);
    logic signed [16:0] s;
    s = $signed({8'b0, q});
    return neg ? -s : s;
  endfunction

endpackage

// ----- rtl/pixel_color_adjust_core.sv -----
// Top level of the pixel color adjust block: contrast, brightness and gain
// steps on the red, green and blue bytes in a seven stage pipeline.
// Depends on pca_pkg.
//
// Throughput is one pixel per cycle; each stage holds when the one after it is
// full and stalled, so bubbles close up. Synchronous active-low reset empties
// the pipeline and sets adjustment off and all percentages to 100.
module pixel_color_adjust_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  pca_pkg::pix_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pca_pkg::pix_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [pca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pca_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pca_pkg::*;

  localparam int unsigned NSTG = 7;

  logic       enable_r;
  logic [6:0] bri_r;
  logic [7:0] con_r;
  logic [7:0] gain_r [3];

  logic [6:0] bri_c;
  logic [7:0] con_c;
  logic [7:0] gain_c [3];
  logic       bypass;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] en;

  pix_in_t pix1_r, pix2_r, pix3_r, pix4_r, pix5_r, pix6_r;
  pix_out_t out_r, out_nxt;

  logic signed [16:0] n1_r [3];
  logic signed [16:0] n3_r [3];
  logic signed [16:0] n5_r [3];
  logic [8:0]         q2_r [3];
  logic [8:0]         q4_r [3];
  logic [8:0]         q6_r [3];
  logic               ng2_r [3];
  logic               ng4_r [3];
  logic               ng6_r [3];

  logic signed [16:0] n1_nxt [3];
  logic signed [16:0] n3_nxt [3];
  logic signed [16:0] n5_nxt [3];
  logic [8:0]         q2_nxt [3];
  logic [8:0]         q4_nxt [3];
  logic [8:0]         q6_nxt [3];
  logic [7:0]         ch_in [3];
  logic [7:0]         ch_out [3];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      bri_r     <= BRIGHTNESS_DEFAULT;
      con_r     <= CONTRAST_DEFAULT;
      gain_r[0] <= GAIN_DEFAULT;
      gain_r[1] <= GAIN_DEFAULT;
      gain_r[2] <= GAIN_DEFAULT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:     enable_r  <= cfg_data[0];
        REG_BRIGHTNESS: bri_r     <= cfg_data[6:0];
        REG_CONTRAST:   con_r     <= cfg_data;
        REG_RED_GAIN:   gain_r[0] <= cfg_data;
        REG_GREEN_GAIN: gain_r[1] <= cfg_data;
        REG_BLUE_GAIN:  gain_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    bri_c = (bri_r < BRI_MIN) ? BRI_MIN : ((bri_r > BRI_MAX) ? BRI_MAX : bri_r);
    con_c = (con_r < PCT_MIN) ? PCT_MIN : ((con_r > PCT_MAX) ? PCT_MAX : con_r);
    for (int i = 0; i < 3; i++) begin
      gain_c[i] = (gain_r[i] < PCT_MIN) ? PCT_MIN :
                  ((gain_r[i] > PCT_MAX) ? PCT_MAX : gain_r[i]);
    end
    bypass = !enable_r ||
             (bri_c == BRIGHTNESS_DEFAULT && con_c == CONTRAST_DEFAULT &&
              gain_c[0] == GAIN_DEFAULT && gain_c[1] == GAIN_DEFAULT &&
              gain_c[2] == GAIN_DEFAULT);
  end

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NSTG-1];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_comb begin
    ch_in[0] = in_data.red_in;
    ch_in[1] = in_data.green_in;
    ch_in[2] = in_data.blue_in;
    for (int i = 0; i < 3; i++) begin
      n1_nxt[i] = ($signed({9'b0, ch_in[i]}) - MID_LEVEL) * $signed({9'b0, con_c}) +
                  ROUND_HALF;
      q2_nxt[i] = quo100(mag17(n1_r[i]));
      n3_nxt[i] = (signed_q(q2_r[i], ng2_r[i]) + MID_LEVEL) *
                  $signed({10'b0, bri_c}) + ROUND_HALF;
      q4_nxt[i] = quo100(mag17(n3_r[i]));
      n5_nxt[i] = signed_q(q4_r[i], ng4_r[i]) * $signed({9'b0, gain_c[i]}) + ROUND_HALF;
      q6_nxt[i] = quo100(mag17(n5_r[i]));
      if (ng6_r[i]) begin
        ch_out[i] = 8'd0;
      end else if (q6_r[i] > MAX_LEVEL) begin
        ch_out[i] = MAX_LEVEL[7:0];
      end else begin
        ch_out[i] = q6_r[i][7:0];
      end
    end
    out_nxt.alpha_out = pix6_r.alpha_in;
    if (bypass) begin
      out_nxt.red_out   = pix6_r.red_in;
      out_nxt.green_out = pix6_r.green_in;
      out_nxt.blue_out  = pix6_r.blue_in;
    end else begin
      out_nxt.red_out   = ch_out[0];
      out_nxt.green_out = ch_out[1];
      out_nxt.blue_out  = ch_out[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pix1_r <= in_data;
      n1_r   <= n1_nxt;
    end
    if (en[1]) begin
      pix2_r <= pix1_r;
      q2_r   <= q2_nxt;
      for (int i = 0; i < 3; i++) ng2_r[i] <= n1_r[i][16];
    end
    if (en[2]) begin
      pix3_r <= pix2_r;
      n3_r   <= n3_nxt;
    end
    if (en[3]) begin
      pix4_r <= pix3_r;
      q4_r   <= q4_nxt;
      for (int i = 0; i < 3; i++) ng4_r[i] <= n3_r[i][16];
    end
    if (en[4]) begin
      pix5_r <= pix4_r;
      n5_r   <= n5_nxt;
    end
    if (en[5]) begin
      pix6_r <= pix5_r;
      q6_r   <= q6_nxt;
      for (int i = 0; i < 3; i++) ng6_r[i] <= n5_r[i][16];
    end
    if (en[6]) begin
      out_r <= out_nxt;
    end
  end

endmodule
